/* hw/rtl/trht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trht_pkg
// shared types and constants for the touch region hit table
// ----------------------------------------------------------------------------
package trht_pkg;

   localparam int unsigned SLOTS_DEF  = 16;
   localparam int unsigned CMD_W      = 3;
   localparam int unsigned COORD_W    = 10;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned SLOT_LIMIT = 2 ** SLOT_W;

   localparam logic [CMD_W-1:0] CMD_ADD        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TOUCH      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ENABLE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISABLE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE_ALL = 3'd5;

   typedef struct packed {
      logic               valid;
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] size_w;
      logic [COORD_W-1:0] size_h;
      logic [SLOT_W-1:0]  slot_index;
      logic               ok;
      logic [SLOT_W-1:0]  slot;
   } trht_token_type;

endpackage

/* hw/rtl/trht_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trht request and response channels
// valid/ready channels carrying one command beat and one result beat
// ----------------------------------------------------------------------------
interface trht_req_if;
   import trht_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] pos_x;
   logic [COORD_W-1:0] pos_y;
   logic [COORD_W-1:0] size_w;
   logic [COORD_W-1:0] size_h;
   logic [SLOT_W-1:0]  slot_index;

   modport source (output valid, cmd, pos_x, pos_y, size_w, size_h, slot_index,
                   input ready);
   modport sink   (input valid, cmd, pos_x, pos_y, size_w, size_h, slot_index,
                   output ready);
endinterface

interface trht_rsp_if;
   import trht_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, ok, slot, input ready);
   modport sink   (input valid, ok, slot, output ready);
endinterface

/* hw/rtl/touch_region_hit_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_region_hit_table
// table of rectangular touch regions kept in a row of slot cells
// ----------------------------------------------------------------------------
// req_chan carries one command beat (add, touch, enable, disable, delete,
// delete all); rsp_chan returns exactly one result beat per command with
// ok and slot. each command walks the row of SLOTS cells as a token, one
// cell per cycle; a cell updates its own slot as the token passes, and add
// and touch take the first cell that claims them.
// the token is registered in each cell in turn and the result then in the
// output register; the next command is accepted only after the token has
// left the row, so only one token is in the row at a time.
// reset clears the used and enabled marks, the token and the valid bits
// of the result and holding registers; rectangles are unknown until added.
// a stalled receiver does not stop the row: a finished result waits in the
// output register, a second one waits in a holding register, and the next
// command is accepted only when the holding register is empty.
// ----------------------------------------------------------------------------
module touch_region_hit_table #(
   parameter int SLOTS = trht_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   trht_req_if.sink    req_chan,
   trht_rsp_if.source  rsp_chan
);
   import trht_pkg::*;

   trht_token_type    tok [SLOTS+1];
   logic              accept;
   logic              exit_valid;

   logic              busy_ff, busy_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_ok_ff, pend_ok_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   assign req_chan.ready = !reset && !busy_ff && !pend_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      tok[0].valid      = accept;
      tok[0].cmd        = req_chan.cmd;
      tok[0].pos_x      = req_chan.pos_x;
      tok[0].pos_y      = req_chan.pos_y;
      tok[0].size_w     = req_chan.size_w;
      tok[0].size_h     = req_chan.size_h;
      tok[0].slot_index = req_chan.slot_index;
      tok[0].ok         = 1'b0;
      tok[0].slot       = '0;
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      trht_cell #(
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

   assign exit_valid = tok[SLOTS].valid;

   always_comb begin
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_ok_in    = pend_ok_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_slot_in   = rsp_slot_ff;

      if (accept) begin
         busy_in = 1'b1;
      end else if (exit_valid) begin
         busy_in = 1'b0;
      end

      if (rsp_valid_ff && !rsp_chan.ready) begin
         if (exit_valid) begin
            pend_valid_in = 1'b1;
            pend_ok_in    = tok[SLOTS].ok;
            pend_slot_in  = tok[SLOTS].slot;
         end
      end else if (pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = pend_ok_ff;
         rsp_slot_in   = pend_slot_ff;
         pend_valid_in = 1'b0;
      end else if (exit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = tok[SLOTS].ok;
         rsp_slot_in  = tok[SLOTS].slot;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pend_ok_ff   <= pend_ok_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_slot_ff  <= rsp_slot_in;
      if (reset) begin
         busy_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ok    = rsp_ok_ff;
   assign rsp_chan.slot  = rsp_slot_ff;

endmodule

/* hw/rtl/trht_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trht_cell
// one table slot: holds its rectangle and marks, acts on the passing token
// ----------------------------------------------------------------------------
module trht_cell #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  trht_pkg::trht_token_type tok_in,
   output trht_pkg::trht_token_type tok_out
);
   import trht_pkg::*;

   localparam bit REACHABLE = (INDEX < SLOT_LIMIT);
   localparam logic [SLOT_W-1:0] MY_SLOT = INDEX[SLOT_W-1:0];

   logic [COORD_W-1:0] left_ff, left_in;
   logic [COORD_W-1:0] top_ff, top_in;
   logic [COORD_W-1:0] width_ff, width_in;
   logic [COORD_W-1:0] height_ff, height_in;
   logic               used_ff, used_in;
   logic               enabled_ff, enabled_in;
   trht_token_type     tok_ff, tok_in_nx;

   logic [COORD_W:0]   right_edge;
   logic [COORD_W:0]   bottom_edge;
   logic               hit;
   logic               selected;

   assign right_edge  = {1'b0, left_ff} + {1'b0, width_ff};
   assign bottom_edge = {1'b0, top_ff} + {1'b0, height_ff};
   assign hit = (tok_in.pos_x > left_ff) && ({1'b0, tok_in.pos_x} < right_edge) &&
                (tok_in.pos_y > top_ff) && ({1'b0, tok_in.pos_y} < bottom_edge);
   assign selected = REACHABLE && (tok_in.slot_index == MY_SLOT);

   always_comb begin
      left_in    = left_ff;
      top_in     = top_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      used_in    = used_ff;
      enabled_in = enabled_ff;
      tok_in_nx  = tok_in;
      if (tok_in.valid) begin
         unique case (tok_in.cmd)
            CMD_ADD: begin
               if (!tok_in.ok && !used_ff) begin
                  left_in        = tok_in.pos_x;
                  top_in         = tok_in.pos_y;
                  width_in       = tok_in.size_w;
                  height_in      = tok_in.size_h;
                  used_in        = 1'b1;
                  enabled_in     = 1'b1;
                  tok_in_nx.ok   = 1'b1;
                  tok_in_nx.slot = MY_SLOT;
               end
            end
            CMD_TOUCH: begin
               if (!tok_in.ok && enabled_ff && hit) begin
                  tok_in_nx.ok   = 1'b1;
                  tok_in_nx.slot = MY_SLOT;
               end
            end
            CMD_ENABLE: begin
               if (selected) enabled_in = 1'b1;
            end
            CMD_DISABLE: begin
               if (selected) enabled_in = 1'b0;
            end
            CMD_DELETE: begin
               if (selected) used_in = 1'b0;
            end
            CMD_DELETE_ALL: begin
               used_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      top_ff    <= top_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      if (reset) begin
         used_ff    <= 1'b0;
         enabled_ff <= 1'b0;
         tok_ff     <= '0;
      end else begin
         used_ff    <= used_in;
         enabled_ff <= enabled_in;
         tok_ff     <= tok_in_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* hw/rtl/trht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trht_checker
// port level checks for the touch region hit table
// ----------------------------------------------------------------------------
module trht_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_ok,
   input logic [trht_pkg::SLOT_W-1:0] rsp_slot
);
   import trht_pkg::*;

   // held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_slot))
      else $error("result beat changed while stalled");

   // failed result reports slot zero
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_slot == '0)
      else $error("failed result with nonzero slot");

   // one command in the row at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while row busy");

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind touch_region_hit_table trht_checker u_trht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_ok    (rsp_chan.ok),
   .rsp_slot  (rsp_chan.slot)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the touch region hit table: a queue of planned
// commands is driven with random gaps, every accepted beat is run through a
// local copy of the region table to predict its reply, and each reply beat
// is compared in order against those predictions
// ----------------------------------------------------------------------------
module tb;
   import trht_pkg::*;

   localparam int unsigned TABLE_SLOTS  = SLOTS_DEF;
   localparam int unsigned RANDOM_ITEMS = 1400;
   localparam int unsigned HOLD_AT      = 300;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_AT     = 700;
   localparam int unsigned QUIET_TAIL   = 150;

   localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] size_w;
      logic [COORD_W-1:0] size_h;
      logic [SLOT_W-1:0]  slot_index;
   } region_cmd_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
   } hit_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   trht_req_if req_chan ();
   trht_rsp_if rsp_chan ();

   touch_region_hit_table #(.SLOTS(TABLE_SLOTS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   region_cmd_type pending_cmds[$];
   hit_reply_type  expected_replies[$];
   region_cmd_type cur_cmd = '0;

   int sent_count     = 0;
   int total_items    = 0;
   int mismatch_count = 0;
   int send_gap       = 0;
   int recv_gap       = 0;
   bit drained        = 1'b0;
   logic long_hold    = 1'b0;

   int adds_placed  = 0;
   int adds_refused = 0;
   int touch_hits   = 0;
   int touch_misses = 0;

   // predicted table contents
   logic [COORD_W-1:0] tbl_left   [TABLE_SLOTS];
   logic [COORD_W-1:0] tbl_top    [TABLE_SLOTS];
   logic [COORD_W-1:0] tbl_width  [TABLE_SLOTS];
   logic [COORD_W-1:0] tbl_height [TABLE_SLOTS];
   bit                 tbl_used    [TABLE_SLOTS];
   bit                 tbl_enabled [TABLE_SLOTS];

   // planning copy, used to aim touches and to keep unwritten slots unread
   int plan_left   [TABLE_SLOTS];
   int plan_top    [TABLE_SLOTS];
   int plan_width  [TABLE_SLOTS];
   int plan_height [TABLE_SLOTS];
   bit plan_used    [TABLE_SLOTS];
   bit plan_written [TABLE_SLOTS];

   function automatic bit between_edges(logic [COORD_W-1:0] p, logic [COORD_W-1:0] start,
                                        logic [COORD_W-1:0] len);
      // far edge formed one bit wider so it never wraps
      return (p > start) && ({1'b0, p} < ({1'b0, start} + {1'b0, len}));
   endfunction

   function automatic hit_reply_type apply_region_cmd(region_cmd_type c);
      hit_reply_type r;
      r = '0;
      case (c.cmd)
         CMD_ADD: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!r.ok && !tbl_used[i]) begin
                  tbl_left[i]    = c.pos_x;
                  tbl_top[i]     = c.pos_y;
                  tbl_width[i]   = c.size_w;
                  tbl_height[i]  = c.size_h;
                  tbl_used[i]    = 1'b1;
                  tbl_enabled[i] = 1'b1;
                  r.ok           = 1'b1;
                  r.slot         = i[SLOT_W-1:0];
               end
            end
            if (r.ok) adds_placed++;
            else adds_refused++;
         end
         CMD_TOUCH: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!r.ok && tbl_enabled[i] &&
                   between_edges(c.pos_x, tbl_left[i], tbl_width[i]) &&
                   between_edges(c.pos_y, tbl_top[i], tbl_height[i])) begin
                  r.ok   = 1'b1;
                  r.slot = i[SLOT_W-1:0];
               end
            end
            if (r.ok) touch_hits++;
            else touch_misses++;
         end
         CMD_ENABLE: begin
            if (c.slot_index < TABLE_SLOTS) tbl_enabled[c.slot_index] = 1'b1;
         end
         CMD_DISABLE: begin
            if (c.slot_index < TABLE_SLOTS) tbl_enabled[c.slot_index] = 1'b0;
         end
         CMD_DELETE: begin
            if (c.slot_index < TABLE_SLOTS) tbl_used[c.slot_index] = 1'b0;
         end
         CMD_DELETE_ALL: begin
            for (int i = 0; i < TABLE_SLOTS; i++) tbl_used[i] = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic region_cmd_type cmd_beat(logic [CMD_W-1:0] cmd, int x, int y, int w,
                                               int h, int idx);
      region_cmd_type c;
      c.cmd        = cmd;
      c.pos_x      = x[COORD_W-1:0];
      c.pos_y      = y[COORD_W-1:0];
      c.size_w     = w[COORD_W-1:0];
      c.size_h     = h[COORD_W-1:0];
      c.slot_index = idx[SLOT_W-1:0];
      return c;
   endfunction

   function automatic void plan_cmd(region_cmd_type c);
      bit placed;
      placed = 1'b0;
      case (c.cmd)
         CMD_ADD: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (!placed && !plan_used[i]) begin
                  plan_used[i]    = 1'b1;
                  plan_written[i] = 1'b1;
                  plan_left[i]    = int'(c.pos_x);
                  plan_top[i]     = int'(c.pos_y);
                  plan_width[i]   = int'(c.size_w);
                  plan_height[i]  = int'(c.size_h);
                  placed          = 1'b1;
               end
            end
         end
         CMD_DELETE: plan_used[c.slot_index] = 1'b0;
         CMD_DELETE_ALL: begin
            for (int i = 0; i < TABLE_SLOTS; i++) plan_used[i] = 1'b0;
         end
         default: ;
      endcase
      pending_cmds.push_back(c);
   endfunction

   function automatic bit idling_allowed();
      return (pending_cmds.size() > QUIET_TAIL) && ((sent_count / 150) % 3 != 2);
   endfunction

   always @(posedge clock) begin : drive_commands
      logic next_valid;
      bit   wait_drain;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_replies.push_back(apply_region_cmd(cur_cmd));
            sent_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            next_valid = 1'b0;
            wait_drain = !drained && (sent_count >= DRAIN_AT) &&
                         (expected_replies.size() != 0);
            if (send_gap > 0) begin
               send_gap--;
            end else if (!wait_drain && pending_cmds.size() != 0) begin
               if (sent_count >= DRAIN_AT) drained = 1'b1;
               cur_cmd    = pending_cmds.pop_front();
               next_valid = 1'b1;
               if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                  send_gap = int'($urandom_range(1, 14));
               end
            end
            req_chan.valid      <= next_valid;
            req_chan.cmd        <= cur_cmd.cmd;
            req_chan.pos_x      <= cur_cmd.pos_x;
            req_chan.pos_y      <= cur_cmd.pos_y;
            req_chan.size_w     <= cur_cmd.size_w;
            req_chan.size_h     <= cur_cmd.size_h;
            req_chan.slot_index <= cur_cmd.slot_index;
         end
      end
   end

   always @(posedge clock) begin : check_replies
      hit_reply_type got;
      hit_reply_type want;
      logic          next_ready;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.ok   = rsp_chan.ok;
            got.slot = rsp_chan.slot;
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("reply beat with none pending: ok=%0b slot=%0d at %0t",
                           got.ok, got.slot, $time);
               end
            end else begin
               want = expected_replies.pop_front();
               if (got.ok !== want.ok || got.slot !== want.slot) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("reply mismatch: expected ok=%0b slot=%0d, %s",
                              want.ok, want.slot, "got");
                     $display("   ok=%0b slot=%0d at %0t", got.ok, got.slot, $time);
                  end
               end
            end
         end
         if (long_hold) begin
            next_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0) begin
               recv_gap = int'($urandom_range(1, 14));
            end
         end
         rsp_chan.ready <= next_ready;
      end
   end

   // long receiver stall so the output and holding registers fill and back up the command side
   initial begin
      wait (sent_count >= HOLD_AT);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #(4_000_000);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      region_cmd_type c;
      int written_ids[$];
      int roll;
      int s;
      int lft;
      int top;
      int wid;
      int hei;
      int hx;
      int hy;

      req_chan.valid      = 1'b0;
      req_chan.cmd        = '0;
      req_chan.pos_x      = '0;
      req_chan.pos_y      = '0;
      req_chan.size_w     = '0;
      req_chan.size_h     = '0;
      req_chan.slot_index = '0;
      rsp_chan.ready      = 1'b0;

      // directed opening
      plan_cmd(cmd_beat(CMD_TOUCH, 0, 0, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_ADD, 0, 0, 1023, 1023, 0));
      plan_cmd(cmd_beat(CMD_ADD, 1000, 1000, 1023, 1023, 0));
      plan_cmd(cmd_beat(CMD_TOUCH, 1023, 1023, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_ADD, 100, 100, 0, 50, 0));
      plan_cmd(cmd_beat(CMD_DISABLE, 0, 0, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_TOUCH, 100, 120, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_DELETE, 0, 0, 0, 0, 1));
      plan_cmd(cmd_beat(CMD_TOUCH, 1023, 1023, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_ENABLE, 0, 0, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_RSVD_6, 1023, 1023, 1023, 1023, 15));
      plan_cmd(cmd_beat(CMD_RSVD_7, 1023, 1023, 1023, 1023, 15));
      for (int i = 0; i < 14; i++) begin
         plan_cmd(cmd_beat(CMD_ADD, 60 * i + 20, 60 * i + 30, 40, 40, 0));
      end
      plan_cmd(cmd_beat(CMD_ADD, 500, 500, 10, 10, 0));
      plan_cmd(cmd_beat(CMD_TOUCH, 1022, 1022, 0, 0, 0));
      plan_cmd(cmd_beat(CMD_DELETE_ALL, 0, 0, 0, 0, 0));

      repeat (RANDOM_ITEMS) begin
         written_ids.delete();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (plan_written[i]) written_ids.push_back(i);
         end
         c.pos_x      = COORD_W'($urandom_range(0, 1023));
         c.pos_y      = COORD_W'($urandom_range(0, 1023));
         c.size_w     = COORD_W'($urandom_range(0, 1023));
         c.size_h     = COORD_W'($urandom_range(0, 1023));
         c.slot_index = SLOT_W'($urandom_range(0, 15));
         roll = int'($urandom_range(0, 99));
         if (roll < 28 || roll >= 92) begin
            c.cmd = CMD_ADD;
            hx = int'($urandom_range(0, 9));
            if (hx == 0) begin
               if (roll[0]) c.size_w = '0;
               else c.size_h = '0;
            end else if (hx > 1) begin
               c.size_w = COORD_W'($urandom_range(2, 300));
               c.size_h = COORD_W'($urandom_range(2, 300));
            end
         end else if (roll < 58) begin
            c.cmd = CMD_TOUCH;
            hy = int'($urandom_range(0, 9));
            if (written_ids.size() != 0 && hy < 8) begin
               s   = written_ids[$urandom_range(0, written_ids.size() - 1)];
               lft = plan_left[s];
               top = plan_top[s];
               wid = plan_width[s];
               hei = plan_height[s];
               if (hy >= 6) begin
                  // on an edge, never strictly inside
                  c.pos_x = COORD_W'(roll[1] ? lft : lft + wid);
                  c.pos_y = COORD_W'(top + hei / 2);
               end else if (wid >= 2 && hei >= 2 && lft < 1023 && top < 1023) begin
                  hx = (wid - 1 < 1023 - lft) ? wid - 1 : 1023 - lft;
                  hy = (hei - 1 < 1023 - top) ? hei - 1 : 1023 - top;
                  c.pos_x = COORD_W'(lft + int'($urandom_range(1, hx)));
                  c.pos_y = COORD_W'(top + int'($urandom_range(1, hy)));
               end
            end
         end else if (roll < 68) begin
            c.cmd = CMD_ENABLE;
            if (!plan_written[c.slot_index]) begin
               if (written_ids.size() != 0) begin
                  c.slot_index =
                     SLOT_W'(written_ids[$urandom_range(0, written_ids.size() - 1)]);
               end else begin
                  c.cmd = CMD_DISABLE;
               end
            end
         end else if (roll < 78) begin
            c.cmd = CMD_DISABLE;
         end else if (roll < 88) begin
            c.cmd = CMD_DELETE;
         end else if (roll < 90) begin
            c.cmd = CMD_DELETE_ALL;
         end else begin
            c.cmd = roll[0] ? CMD_RSVD_6 : CMD_RSVD_7;
         end
         plan_cmd(c);
      end
      total_items = pending_cmds.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (sent_count == total_items);
      wait (expected_replies.size() == 0);
      repeat (4 * TABLE_SLOTS) @(posedge clock);

      $display("covered %0d commands: %0d adds placed, %0d refused on a full table,",
               sent_count, adds_placed, adds_refused);
      $display("%0d touch hits, %0d touch misses, receiver held off %0d cycles, %s",
               touch_hits, touch_misses, HOLD_CYCLES, "sender drained once");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* touch_region_hit_table.f */
hw/rtl/trht_pkg.sv
hw/rtl/trht_if.sv
hw/rtl/trht_cell.sv
hw/rtl/touch_region_hit_table.sv
hw/rtl/trht_checker.sv
bench/tb.sv
